### rtl/core/assert_macros.svh
// Assertion macros used by the scheduler top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/core/psched_pkg.sv
// Types and constants of the process scheduler.
package psched_pkg;

   localparam int ID_W       = 16;
   localparam int PRI_W      = 8;
   localparam int TIME_W     = 22;
   localparam int SUM_W      = 27;
   localparam int SLICE_W    = 16;
   localparam int MODE_W     = 2;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 88;

   localparam logic [TIME_W-1:0] TIME_MAX = 22'h3FFFFF;
   localparam logic [SUM_W-1:0]  SUM_MAX  = 27'h7FFFFFF;
   localparam logic [SLICE_W-1:0] SLICE_RESET = 16'd10;

   localparam logic [MODE_W-1:0] MODE_FCFS = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RR   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PRI  = 2'd2;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_RUN  = 1'b1;

   localparam logic [1:0] STAT_READY   = 2'd0;
   localparam logic [1:0] STAT_WAITING = 2'd1;
   localparam logic [1:0] STAT_RUNNING = 2'd2;
   localparam logic [1:0] STAT_INVALID = 2'd3;

   localparam logic REG_MODE  = 1'b0;
   localparam logic REG_SLICE = 1'b1;

   typedef enum logic [11:0] {
      ST_IDLE     = 12'b0000_0000_0001,
      ST_EMPTY    = 12'b0000_0000_0010,
      ST_STEP     = 12'b0000_0000_0100,
      ST_WAIT_RD  = 12'b0000_0000_1000,
      ST_WAIT_WR  = 12'b0000_0001_0000,
      ST_RDY_MV   = 12'b0000_0010_0000,
      ST_RUN_HEAD = 12'b0000_0100_0000,
      ST_SCAN_RD  = 12'b0000_1000_0000,
      ST_SCAN_CMP = 12'b0001_0000_0000,
      ST_PICK     = 12'b0010_0000_0000,
      ST_REMOVE   = 12'b0100_0000_0000,
      ST_EMIT     = 12'b1000_0000_0000
   } state_type;

endpackage

### rtl/core/psched_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module psched_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

### rtl/core/process_scheduler_fcfs_rr_priority.sv
// Process scheduler top level: queue memories, run sequencer and result register.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_tvalid/req_tready | req_tdata, req_tuser
//   rsp     | out       | rsp_tvalid/rsp_tready | rsp_tdata, rsp_tuser, rsp_tlast
//   csr     | in        | csr_valid/csr_ready   | csr_index, csr_data
//
// A load transaction is taken in the idle state. A run walks the queues: each queue move,
// each completion with its result, and in priority mode a scan of the ready entries for
// each pick, followed by the pick and the removal from the ready queue.
// A memory read that shares a cycle with a write of the same entry is never used.
// The result register lets the sequencer stop only when a new result finds it still full.
// Reset is synchronous and empties all queues; no clearing pass is needed.
`include "assert_macros.svh"

module process_scheduler_fcfs_rr_priority
   import psched_pkg::*;
#(
   parameter int MAX_PROCS = 32,
   parameter int COST_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // proc_id[15:0], status[17:16], cost[33:18], priority_req[41:34], zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // cmd
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // done_id[15:0], finish_time[37:16], wait_time[59:38], total_wait[86:60], zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // empty_run
   output logic                  rsp_tuser,
   output logic                  rsp_tlast,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [SLICE_W-1:0]    csr_data
);

   localparam int AW     = $clog2(MAX_PROCS);
   localparam int CNT_W  = $clog2(MAX_PROCS + 1);
   localparam int COST_W = COST_BITS;
   localparam int CMP_W  = (COST_W > SLICE_W) ? COST_W : SLICE_W;
   localparam int TADD_W = ((CMP_W > TIME_W) ? CMP_W : TIME_W) + 1;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [COST_W-1:0] cost;
      logic [COST_W-1:0] left;
      logic [PRI_W-1:0]  pri;
      logic [AW-1:0]     seq;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   function automatic logic [AW-1:0] addr_wrap(input logic [CNT_W:0] s);
      logic [CNT_W:0] r;
      r = (s >= (CNT_W+1)'(MAX_PROCS)) ? s - (CNT_W+1)'(MAX_PROCS) : s;
      return r[AW-1:0];
   endfunction

   function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
      return (a == AW'(MAX_PROCS - 1)) ? '0 : a + 1'b1;
   endfunction

   function automatic logic [TIME_W-1:0] time_add(input logic [TIME_W-1:0] t,
                                                  input logic [CMP_W-1:0] d);
      logic [TADD_W-1:0] s;
      s = TADD_W'(t) + TADD_W'(d);
      return (s > TADD_W'(TIME_MAX)) ? TIME_MAX : s[TIME_W-1:0];
   endfunction

   state_type state_ff, state_in;
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [SLICE_W-1:0] slice_ff, slice_in;
   logic [AW-1:0] rdy_head_ff, rdy_head_in, wt_head_ff, wt_head_in, run_head_ff, run_head_in;
   logic [CNT_W-1:0] rdy_cnt_ff, rdy_cnt_in, wt_cnt_ff, wt_cnt_in, run_cnt_ff, run_cnt_in;
   logic [CNT_W-1:0] loaded_ff, loaded_in, emit_cnt_ff, emit_cnt_in, scan_n_ff, scan_n_in;
   logic [AW-1:0] seq_ff, seq_in, scan_ff, scan_in, bp_ff, bp_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic take_ff, take_in;
   entry_type cur_ff, cur_in, best_ff, best_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic rsp_user_ff, rsp_user_in, rsp_last_ff, rsp_last_in;

   logic rdy_we, wt_we, run_we;
   logic [AW-1:0] rdy_waddr, wt_waddr, run_waddr, rdy_raddr, wt_raddr, run_raddr;
   entry_type rdy_wdata, wt_wdata, run_wdata, rdy_rdata, wt_rdata, run_rdata;
   logic [ENTRY_W-1:0] rdy_rbits, wt_rbits, run_rbits;

   logic [AW-1:0] rdy_tail, rdy_last, wt_tail, run_tail;
   logic out_free;
   logic [SLICE_W-1:0] slice_eff;
   entry_type load_e, e_v;
   logic [TADD_W-1:0] wdiff;
   logic [TIME_W-1:0] wait_v;
   logic [SUM_W:0] sum_v;
   state_type after_st;
   logic [CNT_W+1:0] queued_total;

   assign rdy_rdata = entry_type'(rdy_rbits);
   assign wt_rdata  = entry_type'(wt_rbits);
   assign run_rdata = entry_type'(run_rbits);

   psched_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_PROCS)) u_ready_ram (
      .clock(clock), .wr_en(rdy_we), .wr_addr(rdy_waddr), .wr_data(rdy_wdata),
      .rd_addr(rdy_raddr), .rd_data(rdy_rbits));

   psched_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_PROCS)) u_waiting_ram (
      .clock(clock), .wr_en(wt_we), .wr_addr(wt_waddr), .wr_data(wt_wdata),
      .rd_addr(wt_raddr), .rd_data(wt_rbits));

   psched_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_PROCS)) u_running_ram (
      .clock(clock), .wr_en(run_we), .wr_addr(run_waddr), .wr_data(run_wdata),
      .rd_addr(run_raddr), .rd_data(run_rbits));

   assign rdy_tail  = addr_wrap((CNT_W+1)'(rdy_head_ff) + (CNT_W+1)'(rdy_cnt_ff));
   assign rdy_last  = addr_wrap((CNT_W+1)'(rdy_head_ff) + (CNT_W+1)'(rdy_cnt_ff - 1'b1));
   assign wt_tail   = addr_wrap((CNT_W+1)'(wt_head_ff) + (CNT_W+1)'(wt_cnt_ff));
   assign run_tail  = addr_wrap((CNT_W+1)'(run_head_ff) + (CNT_W+1)'(run_cnt_ff));
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign slice_eff = (slice_ff == '0) ? SLICE_W'(1) : slice_ff;
   assign after_st  = (wt_cnt_ff != '0) ? ST_WAIT_RD : ST_STEP;

   assign load_e.id   = req_tdata[15:0];
   assign load_e.cost = COST_W'(req_tdata[33:18]);
   assign load_e.left = COST_W'(req_tdata[33:18]);
   assign load_e.pri  = req_tdata[41:34];
   assign load_e.seq  = seq_ff;

   assign wdiff  = TADD_W'(time_ff) - TADD_W'(cur_ff.cost);
   assign wait_v = (TADD_W'(time_ff) >= TADD_W'(cur_ff.cost)) ? wdiff[TIME_W-1:0] : '0;
   assign sum_v  = (SUM_W+1)'(sum_ff) + (SUM_W+1)'(wait_v);

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      slice_in    = slice_ff;
      rdy_head_in = rdy_head_ff;
      wt_head_in  = wt_head_ff;
      run_head_in = run_head_ff;
      rdy_cnt_in  = rdy_cnt_ff;
      wt_cnt_in   = wt_cnt_ff;
      run_cnt_in  = run_cnt_ff;
      loaded_in   = loaded_ff;
      emit_cnt_in = emit_cnt_ff;
      scan_n_in   = scan_n_ff;
      seq_in      = seq_ff;
      scan_in     = scan_ff;
      bp_in       = bp_ff;
      time_in     = time_ff;
      sum_in      = sum_ff;
      take_in     = take_ff;
      cur_in      = cur_ff;
      best_in     = best_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      rsp_last_in = rsp_last_ff;
      rdy_we = 1'b0;
      wt_we  = 1'b0;
      run_we = 1'b0;
      rdy_waddr = rdy_tail;
      wt_waddr  = wt_tail;
      run_waddr = run_tail;
      rdy_wdata = load_e;
      wt_wdata  = load_e;
      run_wdata = load_e;
      rdy_raddr = rdy_head_ff;
      wt_raddr  = wt_head_ff;
      run_raddr = run_head_ff;
      e_v = run_rdata;

      if (csr_valid) begin
         unique case (csr_index)
            REG_MODE:  mode_in  = csr_data[MODE_W-1:0];
            REG_SLICE: slice_in = csr_data;
            default:   ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == CMD_LOAD) begin
                  if (req_tdata[17:16] != STAT_INVALID &&
                      loaded_ff < CNT_W'(MAX_PROCS)) begin
                     unique case (req_tdata[17:16])
                        STAT_READY: begin
                           rdy_we = 1'b1;
                           rdy_cnt_in = rdy_cnt_ff + 1'b1;
                        end
                        STAT_WAITING: begin
                           wt_we = 1'b1;
                           wt_cnt_in = wt_cnt_ff + 1'b1;
                        end
                        default: begin
                           run_we = 1'b1;
                           run_cnt_in = run_cnt_ff + 1'b1;
                        end
                     endcase
                     loaded_in = loaded_ff + 1'b1;
                     seq_in = seq_ff + 1'b1;
                  end
               end else begin
                  time_in = '0;
                  emit_cnt_in = '0;
                  if (loaded_ff == '0) begin
                     state_in = ST_EMPTY;
                  end else if (rdy_cnt_ff == '0 && run_cnt_ff == '0 && wt_cnt_ff != '0) begin
                     state_in = ST_WAIT_RD;
                  end else begin
                     state_in = ST_STEP;
                  end
               end
            end
         end
         ST_EMPTY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = '0;
               rsp_user_in = 1'b1;
               rsp_last_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_STEP: begin
            if (rdy_cnt_ff == '0 && run_cnt_ff == '0) begin
               state_in = ST_IDLE;
            end else if (run_cnt_ff != '0) begin
               state_in = ST_RUN_HEAD;
            end else if (mode_ff == MODE_PRI) begin
               scan_in = rdy_head_ff;
               scan_n_in = '0;
               state_in = ST_SCAN_RD;
            end else begin
               state_in = ST_RDY_MV;
            end
         end
         ST_RDY_MV: begin
            run_we = 1'b1;
            run_wdata = rdy_rdata;
            run_cnt_in = run_cnt_ff + 1'b1;
            rdy_head_in = addr_inc(rdy_head_ff);
            rdy_cnt_in = rdy_cnt_ff - 1'b1;
            state_in = after_st;
         end
         ST_WAIT_RD: begin
            state_in = ST_WAIT_WR;
         end
         ST_WAIT_WR: begin
            rdy_we = 1'b1;
            rdy_wdata = wt_rdata;
            rdy_cnt_in = rdy_cnt_ff + 1'b1;
            wt_head_in = addr_inc(wt_head_ff);
            wt_cnt_in = wt_cnt_ff - 1'b1;
            state_in = ST_STEP;
         end
         ST_RUN_HEAD: begin
            cur_in = run_rdata;
            if (mode_ff == MODE_RR) begin
               run_head_in = addr_inc(run_head_ff);
               run_cnt_in = run_cnt_ff - 1'b1;
               if (CMP_W'(run_rdata.left) <= CMP_W'(slice_eff)) begin
                  time_in = time_add(time_ff, CMP_W'(run_rdata.left));
                  state_in = ST_EMIT;
               end else begin
                  time_in = time_add(time_ff, CMP_W'(slice_eff));
                  e_v.left = COST_W'(CMP_W'(run_rdata.left) - CMP_W'(slice_eff));
                  rdy_we = 1'b1;
                  rdy_wdata = e_v;
                  rdy_cnt_in = rdy_cnt_ff + 1'b1;
                  state_in = after_st;
               end
            end else if (mode_ff == MODE_PRI && rdy_cnt_ff != '0) begin
               scan_in = rdy_head_ff;
               scan_n_in = '0;
               state_in = ST_SCAN_RD;
            end else begin
               run_head_in = addr_inc(run_head_ff);
               run_cnt_in = run_cnt_ff - 1'b1;
               time_in = time_add(time_ff, CMP_W'(run_rdata.cost));
               state_in = ST_EMIT;
            end
         end
         ST_SCAN_RD: begin
            rdy_raddr = scan_ff;
            state_in = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            if (scan_n_ff == '0 || rdy_rdata.pri < best_ff.pri ||
                (rdy_rdata.pri == best_ff.pri && rdy_rdata.seq < best_ff.seq)) begin
               best_in = rdy_rdata;
               bp_in = scan_ff;
            end
            scan_in = addr_inc(scan_ff);
            scan_n_in = scan_n_ff + 1'b1;
            state_in = (scan_n_ff + 1'b1 == rdy_cnt_ff) ? ST_PICK : ST_SCAN_RD;
         end
         ST_PICK: begin
            rdy_raddr = rdy_last;
            if (run_cnt_ff != '0) begin
               if (best_ff.pri < cur_ff.pri) begin
                  time_in = time_add(time_ff, CMP_W'(best_ff.cost));
                  cur_in = best_ff;
                  take_in = 1'b1;
                  rdy_cnt_in = rdy_cnt_ff - 1'b1;
                  state_in = ST_REMOVE;
               end else begin
                  run_head_in = addr_inc(run_head_ff);
                  run_cnt_in = run_cnt_ff - 1'b1;
                  time_in = time_add(time_ff, CMP_W'(cur_ff.cost));
                  state_in = ST_EMIT;
               end
            end else begin
               run_we = 1'b1;
               run_wdata = best_ff;
               run_cnt_in = run_cnt_ff + 1'b1;
               take_in = 1'b0;
               rdy_cnt_in = rdy_cnt_ff - 1'b1;
               state_in = ST_REMOVE;
            end
         end
         ST_REMOVE: begin
            rdy_we = 1'b1;
            rdy_waddr = bp_ff;
            rdy_wdata = rdy_rdata;
            state_in = take_ff ? ST_EMIT : after_st;
         end
         ST_EMIT: begin
            if (out_free) begin
               sum_in = (sum_v > (SUM_W+1)'(SUM_MAX)) ? SUM_MAX : sum_v[SUM_W-1:0];
               rsp_valid_in = 1'b1;
               rsp_data_in = RSP_DATA_W'({sum_in, wait_v, time_ff, cur_ff.id});
               rsp_user_in = 1'b0;
               rsp_last_in = (emit_cnt_ff + 1'b1 == loaded_ff);
               emit_cnt_in = emit_cnt_ff + 1'b1;
               state_in = after_st;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if ((state_ff == ST_EMPTY && out_free) ||
          (state_ff == ST_STEP && rdy_cnt_ff == '0 && run_cnt_ff == '0)) begin
         rdy_head_in = '0;
         wt_head_in  = '0;
         run_head_in = '0;
         rdy_cnt_in  = '0;
         wt_cnt_in   = '0;
         run_cnt_in  = '0;
         loaded_in   = '0;
         emit_cnt_in = '0;
         seq_in      = '0;
         sum_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_FCFS;
         slice_ff     <= SLICE_RESET;
         rdy_head_ff  <= '0;
         wt_head_ff   <= '0;
         run_head_ff  <= '0;
         rdy_cnt_ff   <= '0;
         wt_cnt_ff    <= '0;
         run_cnt_ff   <= '0;
         loaded_ff    <= '0;
         emit_cnt_ff  <= '0;
         seq_ff       <= '0;
         time_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         slice_ff     <= slice_in;
         rdy_head_ff  <= rdy_head_in;
         wt_head_ff   <= wt_head_in;
         run_head_ff  <= run_head_in;
         rdy_cnt_ff   <= rdy_cnt_in;
         wt_cnt_ff    <= wt_cnt_in;
         run_cnt_ff   <= run_cnt_in;
         loaded_ff    <= loaded_in;
         emit_cnt_ff  <= emit_cnt_in;
         seq_ff       <= seq_in;
         time_ff      <= time_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_n_ff   <= scan_n_in;
      scan_ff     <= scan_in;
      bp_ff       <= bp_in;
      take_ff     <= take_in;
      cur_ff      <= cur_in;
      best_ff     <= best_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign queued_total = (CNT_W+2)'(rdy_cnt_ff) + (CNT_W+2)'(wt_cnt_ff) +
                         (CNT_W+2)'(run_cnt_ff) + (CNT_W+2)'(emit_cnt_ff);

   `ASSERT_ALWAYS(a_entries_conserved, queued_total <= (CNT_W+2)'(loaded_ff), "queued entries exceed loads")
   `ASSERT_IMPLIES(a_emit_in_range, state_ff == ST_EMIT, emit_cnt_ff < loaded_ff, "result beyond loaded count")
   `ASSERT_IMPLIES(a_scan_in_range, state_ff == ST_SCAN_CMP, scan_n_ff < rdy_cnt_ff, "scan past ready tail")

endmodule
